/* hdl/qric_pkg.sv */
// ----------------------------------------------------------------------------
// qric_pkg
// Types, widths, constants and helper functions shared by the quadratic
// interpolation coefficient unit.
// ----------------------------------------------------------------------------
package qric_pkg;

    localparam int TAU_WIDTH  = 24;
    localparam int COEF_WIDTH = 32;
    localparam int COEF_FRAC  = COEF_WIDTH - 5;
    localparam int NUM_WIDTH  = 2 * TAU_WIDTH + 48;
    localparam int MB_WIDTH   = (TAU_WIDTH + 2 > 34) ? TAU_WIDTH + 2 : 34;
    localparam int MUL_STEPS  = (MB_WIDTH + 7) / 8;
    localparam int AX_WIDTH   = TAU_WIDTH + 16;
    localparam int T_WIDTH    = 33;
    localparam int CNT_WIDTH  = $clog2(COEF_WIDTH + 1);

    localparam logic [NUM_WIDTH-1:0] ONE_Q32 = NUM_WIDTH'(64'h1_0000_0000);
    localparam logic [NUM_WIDTH-1:0] RECIP5  = NUM_WIDTH'(32'hCCCC_CCCD);
    localparam logic [NUM_WIDTH-1:0] RECIP3  = NUM_WIDTH'(32'hAAAA_AAAB);

    typedef struct packed {
        logic [TAU_WIDTH-1:0] tau_step;
        logic                 column_start;
    } t_in;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] up_u;
        logic signed [COEF_WIDTH-1:0] up_v;
        logic signed [COEF_WIDTH-1:0] up_w;
        logic signed [COEF_WIDTH-1:0] down_u;
        logic signed [COEF_WIDTH-1:0] down_v;
        logic signed [COEF_WIDTH-1:0] down_w;
        logic                         zero_divisor;
    } t_out;

    typedef enum logic [4:0] {
        U_R5, U_H4, U_H3A, U_H3B, U_H2, U_H1,
        U_F0, U_F1, U_F2, U_F3,
        U_I0, U_I1, U_I2, U_I3, U_I4,
        U_AA,
        U_AS, U_N1A, U_N1B, U_Q1, U_N2, U_Q2, U_N3, U_BS, U_Q3
    } t_uop;

    typedef enum logic [1:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        t_uop uop;
        logic set;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic zero;
    } t_stat;

    function automatic logic [31:0] exp_frac_q32(input logic [1:0] idx);
        logic [31:0] v;
        unique case (idx)
            2'd0: v = 32'd4034748381;
            2'd1: v = 32'd3790295335;
            2'd2: v = 32'd3344923893;
            2'd3: v = 32'd2605029348;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] exp_int_q32(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'd1580030169;
            3'd1: v = 32'd581260616;
            3'd2: v = 32'd78665070;
            3'd3: v = 32'd1440801;
            3'd4: v = 32'd483;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic t_uop next_uop(input t_uop u);
        t_uop n;
        unique case (u)
            U_R5:  n = U_H4;
            U_H4:  n = U_H3A;
            U_H3A: n = U_H3B;
            U_H3B: n = U_H2;
            U_H2:  n = U_H1;
            U_H1:  n = U_F0;
            U_F0:  n = U_F1;
            U_F1:  n = U_F2;
            U_F2:  n = U_F3;
            U_F3:  n = U_I0;
            U_I0:  n = U_I1;
            U_I1:  n = U_I2;
            U_I2:  n = U_I3;
            U_I3:  n = U_I4;
            U_I4:  n = U_AA;
            U_AA:  n = U_AS;
            U_AS:  n = U_N1A;
            U_N1A: n = U_N1B;
            U_N1B: n = U_Q1;
            U_Q1:  n = U_N2;
            U_N2:  n = U_Q2;
            U_Q2:  n = U_N3;
            U_N3:  n = U_BS;
            U_BS:  n = U_Q3;
            U_Q3:  n = U_AS;
            default: n = U_R5;
        endcase
        return n;
    endfunction

endpackage

/* hdl/qric_ctrl.sv */
// ----------------------------------------------------------------------------
// qric_ctrl
// Sequencer: tracks the window fill, steps the datapath through its
// micro-operations and owns the output valid flag.
// ----------------------------------------------------------------------------
module qric_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_column_start,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output qric_pkg::t_cmd o_cmd,
    input  qric_pkg::t_stat i_stat
);
    import qric_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_fill, n_fill;
    t_uop       r_uop, n_uop;
    logic       r_set, n_set;
    logic       r_out_valid, n_out_valid;
    logic [1:0] fill_eff;
    logic       full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 2'd0;
            r_uop       <= U_R5;
            r_set       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_uop       <= n_uop;
            r_set       <= n_set;
            r_out_valid <= n_out_valid;
        end
    end

    assign fill_eff = i_column_start ? 2'd0 : r_fill;
    assign full     = fill_eff >= 2'd2;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_uop        = r_uop;
        n_set        = r_set;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.start    = 1'b0;
        o_cmd.uop      = r_uop;
        o_cmd.set      = r_set;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_fill = full ? fill_eff : fill_eff + 2'd1;
                    if (full) begin
                        n_state = S_ISSUE;
                        n_uop   = U_R5;
                        n_set   = 1'b0;
                    end
                end
            end
            S_ISSUE: begin
                if (i_stat.zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_stat.done) begin
                    n_uop = next_uop(r_uop);
                    if (r_uop == U_Q3 && r_set) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ISSUE;
                        if (r_uop == U_Q3) begin
                            n_set = 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/qric_datapath.sv */
// ----------------------------------------------------------------------------
// qric_datapath
// Step window, shared radix-256 multiplier, shared restoring divider,
// coefficient buffer and output register.
// ----------------------------------------------------------------------------
module qric_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qric_pkg::t_in   i_in_data,
    input  qric_pkg::t_cmd  i_cmd,
    output qric_pkg::t_stat o_stat,
    output qric_pkg::t_out  o_out_data
);
    import qric_pkg::*;

    localparam int NW = NUM_WIDTH;
    localparam int CW = COEF_WIDTH;

    logic [TAU_WIDTH-1:0]  r_older, r_middle, r_a, r_prev, r_next;
    logic                  r_zero;
    logic [T_WIDTH-1:0]    r_t, r_e0;
    logic [NW-1:0]         r_e1, r_e2, r_as, r_num, r_den;
    logic [CW-1:0]         r_coef [6];
    t_out                  r_out;

    logic                  r_busy, r_isdiv, r_neg, r_sat;
    t_uop                  r_uop;
    logic [CNT_WIDTH-1:0]  r_cnt;
    logic [NW-1:0]         r_ma, r_macc, r_rem, r_dd;
    logic [MB_WIDTH-1:0]   r_mb;
    logic [CW-1:0]         r_dsh, r_q;

    logic [AX_WIDTH-1:0]   a_x;
    logic [TAU_WIDTH-1:0]  b_sel;
    logic [TAU_WIDTH:0]    s_sum;
    logic [TAU_WIDTH+1:0]  two_a_b;
    logic [NW-1:0]         op_a, dd_sel, num_mag;
    logic [MB_WIDTH-1:0]   op_b;
    logic                  is_div, big_n, ge, last;
    logic [NW:0]           rem2;
    logic [CNT_WIDTH-1:0]  limit;
    logic [CW-1:0]         q_final;
    logic [2:0]            cbase;
    logic [T_WIDTH-1:0]    e_val, e0_val;
    logic [NW-1:0]         e1_val;

    assign a_x     = AX_WIDTH'(r_a);
    assign b_sel   = i_cmd.set ? r_prev : r_next;
    assign s_sum   = (TAU_WIDTH+1)'(r_a) + (TAU_WIDTH+1)'(b_sel);
    assign two_a_b = (TAU_WIDTH+2)'({r_a, 1'b0}) + (TAU_WIDTH+2)'(b_sel);
    assign big_n   = (a_x >> 16) > AX_WIDTH'(31);
    assign is_div  = (i_cmd.uop == U_Q1) || (i_cmd.uop == U_Q2) || (i_cmd.uop == U_Q3);
    assign cbase   = i_cmd.set ? 3'd3 : 3'd0;
    assign num_mag = r_num[NW-1] ? NW'(0) - r_num : r_num;

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        dd_sel = '0;
        unique case (i_cmd.uop)
            U_R5: begin
                op_a = RECIP5;
                op_b = MB_WIDTH'(a_x[11:0]) << 16;
            end
            U_H4, U_H3A, U_H2, U_H1: begin
                op_a = NW'(r_t);
                op_b = MB_WIDTH'(a_x[11:0]);
            end
            U_H3B: begin
                op_a = RECIP3;
                op_b = MB_WIDTH'(r_t);
            end
            U_F0: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_frac_q32(2'd0)); end
            U_F1: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_frac_q32(2'd1)); end
            U_F2: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_frac_q32(2'd2)); end
            U_F3: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_frac_q32(2'd3)); end
            U_I0: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_int_q32(3'd0)); end
            U_I1: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_int_q32(3'd1)); end
            U_I2: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_int_q32(3'd2)); end
            U_I3: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_int_q32(3'd3)); end
            U_I4: begin op_a = NW'(r_t); op_b = MB_WIDTH'(exp_int_q32(3'd4)); end
            U_AA: begin
                op_a = NW'(r_a);
                op_b = MB_WIDTH'(r_a);
            end
            U_AS: begin
                op_a = NW'(r_a);
                op_b = MB_WIDTH'(s_sum);
            end
            U_N1A: begin
                op_a = r_as;
                op_b = MB_WIDTH'(r_e0);
            end
            U_N1B: begin
                op_a = r_e1;
                op_b = MB_WIDTH'(two_a_b);
            end
            U_N2: begin
                op_a = r_e1;
                op_b = MB_WIDTH'(s_sum);
            end
            U_N3: begin
                op_a = r_e1;
                op_b = MB_WIDTH'(r_a);
            end
            U_BS: begin
                op_a = NW'(s_sum);
                op_b = MB_WIDTH'(b_sel);
            end
            U_Q1: dd_sel = r_as << 32;
            U_Q2: dd_sel = NW'(s_sum) << 32;
            U_Q3: dd_sel = r_den;
            default: ;
        endcase
    end

    assign limit = r_isdiv ? CNT_WIDTH'(CW) : CNT_WIDTH'(MUL_STEPS);
    assign last  = r_busy && (r_cnt == limit);
    assign rem2  = {r_rem, r_dsh[CW-1]};
    assign ge    = rem2 >= {1'b0, r_dd};

    always_comb begin
        if (!r_neg) begin
            q_final = (r_sat || r_q[CW-1]) ? {1'b0, {(CW-1){1'b1}}} : r_q;
        end else if (r_sat || (r_q[CW-1] && (r_q[CW-2:0] != '0))) begin
            q_final = {1'b1, {(CW-1){1'b0}}};
        end else begin
            q_final = CW'(0) - r_q;
        end
    end

    assign e_val  = big_n ? T_WIDTH'(0) : r_t;
    assign e0_val = T_WIDTH'(ONE_Q32) - e_val;
    assign e1_val = (NW'(a_x) << 16) - NW'(e0_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_older  <= '0;
            r_middle <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_older  <= r_middle;
                r_middle <= i_in_data.tau_step;
                r_a      <= r_middle;
                r_prev   <= r_older;
                r_next   <= i_in_data.tau_step;
                r_zero   <= (r_middle == '0) || (r_older == '0) ||
                            (i_in_data.tau_step == '0);
            end

            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_isdiv <= is_div;
                r_uop   <= i_cmd.uop;
                r_cnt   <= '0;
                r_ma    <= op_a;
                r_mb    <= op_b;
                r_macc  <= '0;
                r_dd    <= dd_sel;
                r_neg   <= r_num[NW-1];
                r_sat   <= (num_mag >> 5) >= dd_sel;
                r_rem   <= num_mag >> 5;
                r_dsh   <= {num_mag[4:0], {COEF_FRAC{1'b0}}};
                r_q     <= '0;
            end else if (r_busy && !last) begin
                r_cnt <= r_cnt + CNT_WIDTH'(1);
                if (r_isdiv) begin
                    r_rem <= ge ? NW'(rem2 - {1'b0, r_dd}) : NW'(rem2);
                    r_q   <= {r_q[CW-2:0], ge};
                    r_dsh <= r_dsh << 1;
                end else begin
                    r_macc <= r_macc + NW'(r_ma * r_mb[7:0]);
                    r_ma   <= r_ma << 8;
                    r_mb   <= r_mb >> 8;
                end
            end else if (last) begin
                r_busy <= 1'b0;
                unique case (r_uop)
                    U_R5:  r_t <= T_WIDTH'(ONE_Q32 - (r_macc >> 34));
                    U_H4:  r_t <= T_WIDTH'(ONE_Q32 - (r_macc >> 18));
                    U_H3A: r_t <= T_WIDTH'(r_macc >> 16);
                    U_H3B: r_t <= T_WIDTH'(ONE_Q32 - (r_macc >> 33));
                    U_H2:  r_t <= T_WIDTH'(ONE_Q32 - (r_macc >> 17));
                    U_H1:  r_t <= T_WIDTH'(ONE_Q32 - (r_macc >> 16));
                    U_F0:  if (a_x[12]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_F1:  if (a_x[13]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_F2:  if (a_x[14]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_F3:  if (a_x[15]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_I0:  if (a_x[16]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_I1:  if (a_x[17]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_I2:  if (a_x[18]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_I3:  if (a_x[19]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_I4:  if (a_x[20]) r_t <= T_WIDTH'(r_macc >> 32);
                    U_AA: begin
                        r_e0 <= e0_val;
                        r_e1 <= e1_val;
                        r_e2 <= r_macc - (e1_val << 1);
                    end
                    U_AS:  r_as  <= r_macc;
                    U_N1A: r_num <= r_macc + (r_e2 << 32);
                    U_N1B: r_num <= r_num - (r_macc << 16);
                    U_N2:  r_num <= r_macc - (r_e2 << 16);
                    U_N3:  r_num <= (r_e2 << 16) - r_macc;
                    U_BS:  r_den <= r_macc << 16;
                    U_Q1:  r_coef[cbase]        <= q_final;
                    U_Q2:  r_coef[cbase + 3'd1] <= q_final;
                    U_Q3:  r_coef[cbase + 3'd2] <= q_final;
                    default: ;
                endcase
            end

            if (i_cmd.load_out) begin
                if (r_zero) begin
                    r_out.up_u         <= '0;
                    r_out.up_v         <= '0;
                    r_out.up_w         <= '0;
                    r_out.down_u       <= '0;
                    r_out.down_v       <= '0;
                    r_out.down_w       <= '0;
                    r_out.zero_divisor <= 1'b1;
                end else begin
                    r_out.up_u         <= r_coef[0];
                    r_out.up_v         <= r_coef[1];
                    r_out.up_w         <= r_coef[2];
                    r_out.down_u       <= r_coef[3];
                    r_out.down_v       <= r_coef[4];
                    r_out.down_w       <= r_coef[5];
                    r_out.zero_divisor <= 1'b0;
                end
            end
        end
    end

    assign o_stat.done = last;
    assign o_stat.zero = r_zero;
    assign o_out_data  = r_out;

endmodule

/* hdl/quadratic_ray_interp_coeffs_unit.sv */
// ----------------------------------------------------------------------------
// quadratic_ray_interp_coeffs_unit
// Quadratic short-characteristics coefficients for a stream of cell steps.
// ----------------------------------------------------------------------------
// The unit keeps the last two optical-depth steps of a column and, for every
// interior cell, returns one transaction with the upward and downward u, v and
// w coefficients in saturated Q4.27. A step that carries column_start, or that
// arrives while fewer than two earlier steps of its column are held, gives no
// transaction. A cell with a zero step in its window skips the arithmetic
// and gives an all-zero transaction with zero_divisor set. Any other cell
// runs 28 products on the shared radix-256 multiplier and 6 quotients on
// the shared restoring divider; the result is then loaded into the output
// register once the output is free, and the next step is taken after that.
// A new step is taken while the previous result still waits on the output.
module quadratic_ray_interp_coeffs_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  qric_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output qric_pkg::t_out o_out_data
);
    import qric_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    qric_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_column_start (i_in_data.column_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cmd          (cmd),
        .i_stat         (stat)
    );

    qric_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadratic interpolation coefficient unit.
// A directed run of edge steps, then random grid columns, is driven through
// the input channel while a scoreboard predicts each interior cell's
// coefficients and compares every output transaction against it.
// ----------------------------------------------------------------------------
class coef_scoreboard;
    localparam int MAXPOS = 32'h7FFF_FFFF;

    logic [63:0]        prev_step;
    logic [63:0]        mid_step;
    int                 fill;
    qric_pkg::t_out     expected_q[$];
    int                 mismatches;

    function new();
        prev_step  = 0;
        mid_step   = 0;
        fill       = 0;
        mismatches = 0;
    endfunction

    function logic [63:0] exp_neg_q32(logic [63:0] d);
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] ftab [4];
        logic [63:0] itab [5];
        ftab = '{64'd4034748381, 64'd3790295335, 64'd3344923893, 64'd2605029348};
        itab = '{64'd1580030169, 64'd581260616, 64'd78665070, 64'd1440801, 64'd483};
        r = d & 64'hFFF;
        t = (64'd1 << 32) - (r << 16) / 5;
        t = (64'd1 << 32) - ((r * t) >> 16) / 4;
        t = (64'd1 << 32) - ((r * t) >> 16) / 3;
        t = (64'd1 << 32) - ((r * t) >> 16) / 2;
        t = (64'd1 << 32) - ((r * t) >> 16);
        for (int i = 0; i < 4; i++)
            if (d[12+i]) t = (t * ftab[i]) >> 32;
        n = d >> 16;
        if (n >= 32) return 0;
        for (int i = 0; i < 5; i++)
            if (n[i]) t = (t * itab[i]) >> 32;
        return t;
    endfunction

    function logic [31:0] sat_quotient(logic [127:0] num, logic [127:0] den);
        logic         neg;
        logic         sat;
        logic         bitv;
        logic         qb;
        logic [127:0] m;
        logic [127:0] r;
        logic [63:0]  q;
        neg = num[127];
        m   = neg ? -num : num;
        r   = 0;
        q   = 0;
        sat = 0;
        for (int i = 127 + 27; i >= 0; i--) begin
            bitv = (i >= 27) ? m[i-27] : 1'b0;
            r = {r[126:0], bitv};
            qb = 0;
            if (r >= den) begin
                r = r - den;
                qb = 1;
            end
            if (!sat) begin
                q = {q[62:0], qb};
                if (q[63:62] != 0) sat = 1;
            end
        end
        if (!neg) return (sat || q > MAXPOS) ? MAXPOS : q[31:0];
        if (sat || q > 64'(MAXPOS) + 1) q = 64'(MAXPOS) + 1;
        q = -q;
        return q[31:0];
    endfunction

    function void coef_triple(logic [63:0] a, logic [63:0] b, logic [127:0] e0,
                              logic [127:0] e1, logic [127:0] e2,
                              output logic [31:0] u, output logic [31:0] v,
                              output logic [31:0] w);
        logic [127:0] aa;
        logic [127:0] bb;
        logic [127:0] ss;
        logic [127:0] as_p;
        logic [127:0] num;
        logic [63:0]  k;
        aa   = a;
        bb   = b;
        ss   = 128'(a + b);
        as_p = aa * ss;
        k    = 2 * a + b;
        num  = e0 * as_p + (e2 << 32);
        num  = num - ((128'(k) * e1) << 16);
        u    = sat_quotient(num, as_p << 32);
        num  = e1 * ss - (e2 << 16);
        v    = sat_quotient(num, ss << 32);
        num  = (e2 << 16) - aa * e1;
        w    = sat_quotient(num, (bb * ss) << 16);
    endfunction

    function void note_cell(qric_pkg::t_in item);
        logic [63:0]    d;
        logic [63:0]    a;
        logic [127:0]   e0;
        logic [127:0]   e1;
        logic [127:0]   e2;
        qric_pkg::t_out res;
        d = item.tau_step;
        if (item.column_start) fill = 0;
        if (fill >= 2) begin
            a   = mid_step;
            res = '0;
            if (a == 0 || prev_step == 0 || d == 0) begin
                res.zero_divisor = 1;
            end else begin
                e0 = 128'((64'd1 << 32) - exp_neg_q32(a));
                e1 = 128'(a << 16) - e0;
                e2 = 128'(a) * 128'(a) - (e1 << 1);
                coef_triple(a, d, e0, e1, e2, res.up_u, res.up_v, res.up_w);
                coef_triple(a, prev_step, e0, e1, e2, res.down_u, res.down_v, res.down_w);
            end
            expected_q.push_back(res);
        end
        prev_step = mid_step;
        mid_step  = d;
        if (fill < 2) fill++;
    endfunction

    function void check_result(qric_pkg::t_out got);
        qric_pkg::t_out want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", got);
            return;
        end
        want = expected_q.pop_front();
        if (got.up_u !== want.up_u || got.up_v !== want.up_v || got.up_w !== want.up_w ||
            got.down_u !== want.down_u || got.down_v !== want.down_v ||
            got.down_w !== want.down_w || got.zero_divisor !== want.zero_divisor) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h actual %h", want, got);
        end
    endfunction
endclass

module tb;
    import qric_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    t_in            i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    t_out           o_out_data;

    coef_scoreboard sb;
    int             tx_idle;
    int             rx_idle;
    int             cycles;

    quadratic_ray_interp_coeffs_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    task automatic send_cell(logic [TAU_WIDTH-1:0] d, logic col);
        bit taken;
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid             <= 1'b1;
        i_in_data.tau_step     <= d;
        i_in_data.column_start <= col;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            if (o_in_ready) begin
                taken = 1;
                sb.note_cell(i_in_data);
            end
        end
        @(negedge i_clk);
    endtask

    function automatic logic [TAU_WIDTH-1:0] rand_step();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(255);
            2: return 24'hFFFFFF - $urandom_range(255);
            3: return {($urandom_range(1) ? 8'($urandom_range(32, 255)) : 8'd0),
                       16'($urandom)};
            4, 5: return 24'($urandom_range(20'hFFFFF));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin
        int                   sent;
        int                   len;
        logic [TAU_WIDTH-1:0] directed [$];
        sb          = new();
        tx_idle     = 33;
        rx_idle     = 52;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed = '{24'h010000, 24'hFFFFFF, 24'h000001, 24'h200000, 24'h1FFFFF,
                     24'h00F000, 24'h000FFF, 24'h0, 24'h018000, 24'h100000,
                     24'hFFFFFF, 24'hFFFFFF, 24'h000001, 24'h000001, 24'h0000FF};
        foreach (directed[i]) send_cell(directed[i], i == 0);
        send_cell(24'h008000, 1'b1);
        send_cell(24'h0, 1'b0);
        send_cell(24'h030000, 1'b1);
        send_cell(24'h040000, 1'b0);
        send_cell(24'h050000, 1'b0);
        send_cell(24'h060000, 1'b0);
        drain();

        sent = 0;
        while (sent < 750) begin
            if (sent >= 250 && sent < 500) begin
                tx_idle = 52;
                rx_idle = 33;
            end else if (sent >= 500) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (sent >= 375 && sent < 385) drain();
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            for (int k = 0; k < len; k++) begin
                send_cell(rand_step(), k == 0);
                sent++;
            end
        end
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
